// File: hdl/evs_pkg.sv
// ----------------------------------------------------------------------------
// evs_pkg
// Shared widths, reset values, codes and bundles of the energy VAD segmenter.
// ----------------------------------------------------------------------------
package evs_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 16;
    localparam int THR_W     = 16;
    localparam int MS_W      = 20;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_CHUNK_DEF = 4096;

    localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(328);
    localparam logic [MS_W-1:0]  MIN_SPEECH_RST   = MS_W'(5000);
    localparam logic [MS_W-1:0]  MAX_SPEECH_RST   = MS_W'(5000);
    localparam logic [MS_W-1:0]  SILENCE_HOLD_RST = MS_W'(1000);

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef enum logic [1:0] {
        REASON_NONE    = 2'd0,
        REASON_MAX     = 2'd1,
        REASON_SILENCE = 2'd2,
        REASON_FINISH  = 2'd3
    } stop_reason_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_MIN_SPEECH   = 2'd1,
        CFG_MAX_SPEECH   = 2'd2,
        CFG_SILENCE_HOLD = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [THR_W-1:0] amplitude_threshold;
        logic [MS_W-1:0]  min_speech_ms;
        logic [MS_W-1:0]  max_speech_ms;
        logic [MS_W-1:0]  silence_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       chunk_last;
        logic [TIME_W-1:0]          now_ms;
    } item_t;

    typedef struct packed {
        logic         segment_done;
        stop_reason_t stop_reason;
        logic         recording;
        logic         has_sound;
    } result_t;

endpackage

// File: hdl/evs_if.sv
// ----------------------------------------------------------------------------
// evs_if
// Valid/ready channels of the segmenter: sample input, result output, config.
// ----------------------------------------------------------------------------
interface evs_in_if
    import evs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       chunk_last;
    logic [TIME_W-1:0]          now_ms;

    modport source (output valid, action, sample, chunk_last, now_ms, input ready);
    modport sink   (input valid, action, sample, chunk_last, now_ms, output ready);
endinterface

interface evs_out_if;
    logic       valid;
    logic       ready;
    logic       segment_done;
    logic [1:0] stop_reason;
    logic       recording;
    logic       has_sound;

    modport source (output valid, segment_done, stop_reason, recording, has_sound,
                    input ready);
    modport sink   (input valid, segment_done, stop_reason, recording, has_sound,
                    output ready);
endinterface

interface evs_cfg_if
    import evs_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MS_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/evs_core.sv
// ----------------------------------------------------------------------------
// evs_core
// Chunk accumulator and segment state: decides sound and stop for one item.
// ----------------------------------------------------------------------------
module evs_core
    import evs_pkg::*;
#(
    parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    commit,
    output logic    has_result,
    output result_t result
);

    localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
    localparam int SUM_W  = CNT_W + 15;
    localparam int PROD_W = THR_W + CNT_W;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              open_reg, open_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] last_reg, last_next;

    logic [MAG_W-1:0]  mag;
    logic              take;
    logic [SUM_W-1:0]  sum_acc;
    logic [CNT_W-1:0]  count_acc;
    logic [PROD_W-1:0] prod;
    logic              sound;
    logic [TIME_W-1:0] speech_open;
    logic [TIME_W-1:0] quiet_old;
    logic              max_open, min_open, sil_old;
    logic              max_zero, min_zero, hold_zero;
    logic              stop_max, stop_sil;
    logic              open_eff;
    stop_reason_t      reason;

    always_comb
    begin
        mag       = item.sample[SAMPLE_W-1] ? MAG_W'(~item.sample + 1'b1) : MAG_W'(item.sample);
        take      = count_reg < CNT_W'(MAX_CHUNK);
        sum_acc   = take ? sum_reg + SUM_W'(mag) : sum_reg;
        count_acc = take ? count_reg + 1'b1 : count_reg;
        prod      = PROD_W'(cfg.amplitude_threshold) * PROD_W'(count_acc);
        sound     = PROD_W'(sum_acc) > prod;

        // durations for both outcomes, picked once sound is known
        speech_open = item.now_ms - start_reg;
        quiet_old   = item.now_ms - last_reg;
        max_open    = speech_open >= TIME_W'(cfg.max_speech_ms);
        min_open    = speech_open >= TIME_W'(cfg.min_speech_ms);
        sil_old     = quiet_old >= TIME_W'(cfg.silence_hold_ms);
        max_zero    = cfg.max_speech_ms == '0;
        min_zero    = cfg.min_speech_ms == '0;
        hold_zero   = cfg.silence_hold_ms == '0;

        open_eff = open_reg || sound;
        priority if (sound && !open_reg)
        begin
            stop_max = max_zero;
            stop_sil = hold_zero && min_zero;
        end
        else if (sound)
        begin
            stop_max = max_open;
            stop_sil = hold_zero && min_open;
        end
        else if (open_reg)
        begin
            stop_max = max_open;
            stop_sil = sil_old && min_open;
        end
        else
        begin
            stop_max = 1'b0;
            stop_sil = 1'b0;
        end

        priority if (stop_max)
            reason = REASON_MAX;
        else if (stop_sil)
            reason = REASON_SILENCE;
        else
            reason = REASON_NONE;

        has_result = (item.action == ACT_FINISH) || item.chunk_last;

        sum_next   = sum_reg;
        count_next = count_reg;
        open_next  = open_reg;
        start_next = start_reg;
        last_next  = last_reg;

        if (item.action == ACT_FINISH)
        begin
            result.segment_done = open_reg;
            result.stop_reason  = open_reg ? REASON_FINISH : REASON_NONE;
            result.recording    = 1'b0;
            result.has_sound    = 1'b0;
            open_next  = 1'b0;
            start_next = '0;
        end
        else
        begin
            result.segment_done = reason != REASON_NONE;
            result.stop_reason  = reason;
            result.recording    = open_eff && (reason == REASON_NONE);
            result.has_sound    = sound;
            if (item.chunk_last)
            begin
                sum_next   = '0;
                count_next = '0;
                if (sound)
                    last_next = item.now_ms;
                if (reason != REASON_NONE)
                begin
                    open_next  = 1'b0;
                    start_next = '0;
                end
                else if (sound && !open_reg)
                begin
                    open_next  = 1'b1;
                    start_next = item.now_ms;
                end
            end
            else
            begin
                sum_next   = sum_acc;
                count_next = count_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            open_reg  <= 1'b0;
            start_reg <= '0;
            last_reg  <= '0;
        end
        else if (commit)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            open_reg  <= open_next;
            start_reg <= start_next;
            last_reg  <= last_next;
        end
    end

endmodule

// File: hdl/energy_vad_segmenter.sv
// ----------------------------------------------------------------------------
// energy_vad_segmenter
// Energy-based voice activity detector that cuts a sample stream into segments.
// ----------------------------------------------------------------------------
// Takes one item per clock while results are taken: a sample or a finish
// action. Every item goes through an input register and, if it ends a chunk
// or is a finish, leaves as one result from the result register. The whole
// chunk decision (threshold times sample count, compare, duration checks) is
// done combinationally between those two registers, so the input side keeps
// taking one item per cycle for as long as results are taken. Mid-chunk
// samples produce no result. Configuration is taken at any time and is meant
// to be written only while no item is in flight.
module energy_vad_segmenter
    import evs_pkg::*;
#(
    parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    evs_in_if.sink    samples,
    evs_out_if.source results,
    evs_cfg_if.sink   cfg
);

    cfg_t    cfg_reg;
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;

    logic    s1_has_result;
    result_t s1_result;
    logic    out_free;
    logic    s1_fire;
    logic    in_fire;

    evs_core #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (s1_item_reg),
        .commit     (s1_fire),
        .has_result (s1_has_result),
        .result     (s1_result)
    );

    assign out_free      = !out_valid_reg || results.ready;
    assign s1_fire       = s1_valid_reg && (!s1_has_result || out_free);
    assign samples.ready = !s1_valid_reg || s1_fire;
    assign in_fire       = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    assign results.valid        = out_valid_reg;
    assign results.segment_done = out_result_reg.segment_done;
    assign results.stop_reason  = out_result_reg.stop_reason;
    assign results.recording    = out_result_reg.recording;
    assign results.has_sound    = out_result_reg.has_sound;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude_threshold <= THRESHOLD_RST;
            cfg_reg.min_speech_ms       <= MIN_SPEECH_RST;
            cfg_reg.max_speech_ms       <= MAX_SPEECH_RST;
            cfg_reg.silence_hold_ms     <= SILENCE_HOLD_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_THRESHOLD:    cfg_reg.amplitude_threshold <= cfg.data[THR_W-1:0];
                CFG_MIN_SPEECH:   cfg_reg.min_speech_ms       <= cfg.data;
                CFG_MAX_SPEECH:   cfg_reg.max_speech_ms       <= cfg.data;
                CFG_SILENCE_HOLD: cfg_reg.silence_hold_ms     <= cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire && s1_has_result)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.action     <= samples.action;
            s1_item_reg.sample     <= samples.sample;
            s1_item_reg.chunk_last <= samples.chunk_last;
            s1_item_reg.now_ms     <= samples.now_ms;
        end
        if (s1_fire && s1_has_result)
            out_result_reg <= s1_result;
    end

endmodule

// File: hdl/evs_checker.sv
// ----------------------------------------------------------------------------
// evs_checker
// Port-level checks on the result stream of the segmenter, bound to the top.
// ----------------------------------------------------------------------------
module evs_checker
    import evs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       segment_done,
    input logic [1:0] stop_reason,
    input logic       recording,
    input logic       has_sound
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(segment_done)
            && $stable(stop_reason) && $stable(recording) && $stable(has_sound))
        else $error("result changed while stalled");

    a_reason_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !segment_done |-> stop_reason == REASON_NONE)
        else $error("stop reason without segment close");

    // a closing segment is never still recording
    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && segment_done |-> !recording && stop_reason != REASON_NONE)
        else $error("closed segment still recording");

    // sound opens a segment unless it closed on the same chunk
    a_sound_opens: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_sound && !segment_done |-> recording)
        else $error("sound without open segment");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_reason == REASON_FINISH |-> !has_sound)
        else $error("finish result reports sound");

endmodule

bind energy_vad_segmenter evs_checker u_evs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .segment_done (results.segment_done),
    .stop_reason  (results.stop_reason),
    .recording    (results.recording),
    .has_sound    (results.has_sound)
);
